// ----- rtl/dtpm_pkg.sv -----
// ----------------------------------------------------------------------------
// dtpm_pkg
// Shared types and constants for the depth-tested pixel merge block.
// ----------------------------------------------------------------------------
package dtpm_pkg;

  // Request kinds.
  localparam logic KIND_FRAGMENT = 1'b0;
  localparam logic KIND_READ     = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Configuration data is as wide as the widest register.
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_DATA_W-1:0] FRAME_SIZE_RESET = 9'd256;

  // One input request.
  typedef struct packed {
    logic               kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        color_red;
    logic [15:0]        color_green;
    logic [15:0]        color_blue;
    logic [7:0]         read_x;
    logic [7:0]         read_y;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic        depth_passed;
    logic        out_of_range;
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [16:0] stored_depth;
    logic [15:0] stored_red;
    logic [15:0] stored_green;
    logic [15:0] stored_blue;
  } out_res_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_PIXEL,
    ST_READ,
    ST_UPDATE
  } state_t;

endpackage

// ----- rtl/depth_tested_pixel_merge.sv -----
// ----------------------------------------------------------------------------
// depth_tested_pixel_merge
// Z-buffer output merger: maps fragments to pixels, depth tests them against
// a depth store and merges their color into a color store.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on in_req when start is high and busy is low. A
//   fragment request maps its position to a pixel, tests its depth against
//   the depth store and writes depth and color on a strict win. A read
//   request returns the stored pixel at read_x, read_y.
//   Every request gives one result on out_res, shown for one cycle with
//   out_valid high. The receiver cannot stall, so results are never held.
//   One request is worked on at a time; busy is high until its result is shown.
//   The steps follow the read-modify-write of the stores: scale multiply,
//   pixel rounding and address, memory read, then update. The frame size
//   registers are written on cfg_we with cfg_index and cfg_data; the user
//   must write them only while no request is in flight, as the block does
//   not enforce it. They take effect for the next request. After reset
//   both stores are swept to zero, one entry per cycle, over all
//   MAX_WIDTH*MAX_HEIGHT entries; busy is high during the sweep.
// ----------------------------------------------------------------------------
module depth_tested_pixel_merge #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  dtpm_pkg::in_req_t                  in_req,
  output logic                               out_valid,
  output dtpm_pkg::out_res_t                 out_res,
  input  logic                               cfg_we,
  input  logic [dtpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dtpm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // Maps a Q1.15 coordinate to a pixel from the registered scale product.
  function automatic logic [8:0] round_pixel(input logic [24:0] t, input logic [8:0] size);
    logic [9:0]  q;
    logic [14:0] r;
    logic        inc;
    logic [10:0] qs;
    q   = t[24:15];
    r   = t[14:0];
    inc = (r > 15'h4000) || ((r == 15'h4000) && (q[0] ^ size[0]));
    qs  = {1'b0, q} + {10'd0, inc};
    return qs[9:1];
  endfunction

  dtpm_pkg::state_t state_r, state_nxt;

  logic [8:0]               fw_r, fh_r;
  logic [AW-1:0]            clr_cnt_r;
  dtpm_pkg::in_req_t        req_r;
  logic [24:0]              tx_r, ty_r;
  logic [16:0]              d_r;
  logic [8:0]               px_r, py_r;
  logic                     oor_r;
  logic [AW-1:0]            addr_r;
  logic [16:0]              rd_depth_r;
  logic [47:0]              rd_color_r;
  logic                     out_valid_r;
  dtpm_pkg::out_res_t       out_res_r;

  logic [16:0] depth_mem [DEPTH];
  logic [47:0] color_mem [DEPTH];

  logic [8:0]  px_c, py_c;
  logic        oor_c;
  logic        pass_c;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [16:0] mem_wd_depth;
  logic [47:0] mem_wd_color;
  logic [47:0] new_color;
  logic signed [17:0] zd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= dtpm_pkg::FRAME_SIZE_RESET;
      fh_r <= dtpm_pkg::FRAME_SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == dtpm_pkg::CFG_FRAME_WIDTH) begin
        fw_r <= cfg_data;
      end
      if (cfg_index == dtpm_pkg::CFG_FRAME_HEIGHT) begin
        fh_r <= cfg_data;
      end
    end
  end

  // Sequencer state and clearing counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtpm_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == dtpm_pkg::ST_UPDATE);
      if (state_r == dtpm_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dtpm_pkg::ST_CLEAR: begin
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = dtpm_pkg::ST_IDLE;
        end
      end
      dtpm_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = dtpm_pkg::ST_MAP;
        end
      end
      dtpm_pkg::ST_MAP:    state_nxt = dtpm_pkg::ST_PIXEL;
      dtpm_pkg::ST_PIXEL:  state_nxt = dtpm_pkg::ST_READ;
      dtpm_pkg::ST_READ:   state_nxt = dtpm_pkg::ST_UPDATE;
      dtpm_pkg::ST_UPDATE: state_nxt = dtpm_pkg::ST_IDLE;
      default:             state_nxt = dtpm_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_r != dtpm_pkg::ST_IDLE);

  // Depth of the fragment: 32768 - z, in 1..65536.
  assign zd = 18'sd32768 - 18'(req_r.pos_z);

  // Capture the request, then scale the coordinates by the frame size.
  always_ff @(posedge clk) begin
    if (state_r == dtpm_pkg::ST_IDLE && start) begin
      req_r <= in_req;
    end
    if (state_r == dtpm_pkg::ST_MAP) begin
      tx_r <= 25'({~req_r.pos_x[15], req_r.pos_x[14:0]}) * 25'(fw_r);
      ty_r <= 25'({~req_r.pos_y[15], req_r.pos_y[14:0]}) * 25'(fh_r);
      d_r  <= zd[16:0];
    end
  end

  // Round to a pixel, check the frame and form the store address.
  always_comb begin
    if (req_r.kind == dtpm_pkg::KIND_FRAGMENT) begin
      px_c = round_pixel(tx_r, fw_r);
      py_c = round_pixel(ty_r, fh_r);
    end else begin
      px_c = {1'b0, req_r.read_x};
      py_c = {1'b0, req_r.read_y};
    end
    oor_c = (px_c >= fw_r) || (32'(px_c) >= 32'(MAX_WIDTH)) ||
            (py_c >= fh_r) || (32'(py_c) >= 32'(MAX_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (state_r == dtpm_pkg::ST_PIXEL) begin
      px_r   <= px_c;
      py_r   <= py_c;
      oor_r  <= oor_c;
      addr_r <= AW'(py_c) * AW'(MAX_WIDTH) + AW'(px_c);
    end
  end

  // Depth test and store write port, shared with the clearing sweep.
  assign new_color = {req_r.color_blue, req_r.color_green, req_r.color_red};
  assign pass_c    = !oor_r && (req_r.kind == dtpm_pkg::KIND_FRAGMENT) && (d_r > rd_depth_r);

  always_comb begin
    if (state_r == dtpm_pkg::ST_CLEAR) begin
      mem_we       = 1'b1;
      mem_wa       = clr_cnt_r;
      mem_wd_depth = '0;
      mem_wd_color = '0;
    end else begin
      mem_we       = (state_r == dtpm_pkg::ST_UPDATE) && pass_c;
      mem_wa       = addr_r;
      mem_wd_depth = d_r;
      mem_wd_color = new_color;
    end
  end

  // Depth and color stores: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[mem_wa] <= mem_wd_depth;
      color_mem[mem_wa] <= mem_wd_color;
    end
    rd_depth_r <= depth_mem[addr_r];
    rd_color_r <= color_mem[addr_r];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state_r == dtpm_pkg::ST_UPDATE) begin
      out_res_r.depth_passed <= pass_c;
      out_res_r.out_of_range <= oor_r;
      out_res_r.pixel_x      <= px_r;
      out_res_r.pixel_y      <= py_r;
      if (oor_r) begin
        out_res_r.stored_depth <= '0;
        out_res_r.stored_red   <= '0;
        out_res_r.stored_green <= '0;
        out_res_r.stored_blue  <= '0;
      end else if (pass_c) begin
        out_res_r.stored_depth <= d_r;
        out_res_r.stored_red   <= req_r.color_red;
        out_res_r.stored_green <= req_r.color_green;
        out_res_r.stored_blue  <= req_r.color_blue;
      end else begin
        out_res_r.stored_depth <= rd_depth_r;
        out_res_r.stored_red   <= rd_color_r[15:0];
        out_res_r.stored_green <= rd_color_r[31:16];
        out_res_r.stored_blue  <= rd_color_r[47:32];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ----- dv/depth_tested_pixel_merge_checker.sv -----
// ----------------------------------------------------------------------------
// Depth-tested pixel merge checker
// Watches the request, result and frame size ports of the merge block. It
// keeps its own depth and color stores, predicts the result of every
// accepted request, and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module depth_tested_pixel_merge_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  dtpm_pkg::in_req_t               in_req,
  input  logic                            out_valid,
  input  dtpm_pkg::out_res_t              out_res,
  input  logic                            cfg_we,
  input  logic [dtpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtpm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     pending,
  output int unsigned                     failures
);
  timeunit 1ns;
  timeprecision 1ps;
  import dtpm_pkg::*;

  localparam int unsigned FRAME_MAX_W = 256;
  localparam int unsigned FRAME_MAX_H = 256;

  // Mirror of the block's stores and frame size registers.
  logic [16:0]    depth_mem [FRAME_MAX_W*FRAME_MAX_H];
  logic [47:0]    color_mem [FRAME_MAX_W*FRAME_MAX_H];
  logic [8:0]     frame_w;
  logic [8:0]     frame_h;
  out_res_t       expected_results[$];
  int unsigned    mismatch_count = 0;
  int unsigned    waiting = 0;

  assign failures = mismatch_count;
  assign pending  = waiting;

  // Scale a Q1.15 coordinate by the frame size, round half to even, then
  // offset by the size and halve.
  function automatic logic [8:0] ndc_to_pixel(input logic signed [15:0] pos,
                                              input logic [8:0] size);
    int unsigned scaled;
    int unsigned whole;
    logic [14:0] frac;
    scaled = unsigned'(int'(pos) + 32768) * size;
    whole  = scaled >> 15;
    frac   = scaled[14:0];
    if (frac > 15'h4000 || (frac == 15'h4000 && ((whole + size) % 2 == 1)))
      whole++;
    return 9'(whole >> 1);
  endfunction

  // Work out the result of one request and update the stores the same way.
  function automatic out_res_t apply_request(input in_req_t r);
    out_res_t    res;
    logic [8:0]  px;
    logic [8:0]  py;
    logic [16:0] depth;
    logic [15:0] addr;
    res = '0;
    if (r.kind == KIND_FRAGMENT) begin
      px = ndc_to_pixel(r.pos_x, frame_w);
      py = ndc_to_pixel(r.pos_y, frame_h);
    end else begin
      px = {1'b0, r.read_x};
      py = {1'b0, r.read_y};
    end
    res.pixel_x      = px;
    res.pixel_y      = py;
    res.out_of_range = px >= frame_w || px >= FRAME_MAX_W ||
                       py >= frame_h || py >= FRAME_MAX_H;
    if (!res.out_of_range) begin
      addr = {py[7:0], px[7:0]};
      // Only a strictly deeper fragment wins the pixel.
      if (r.kind == KIND_FRAGMENT) begin
        depth = 17'(32768 - int'(r.pos_z));
        if (depth > depth_mem[addr]) begin
          depth_mem[addr]  = depth;
          color_mem[addr]  = {r.color_blue, r.color_green, r.color_red};
          res.depth_passed = 1'b1;
        end
      end
      res.stored_depth = depth_mem[addr];
      {res.stored_blue, res.stored_green, res.stored_red} = color_mem[addr];
    end
    return res;
  endfunction

  // Report one field that differs from its prediction.
  function automatic bit field_differs(input string name, input logic [16:0] want,
                                       input logic [16:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    out_res_t want;
    bit       bad;
    if (!rst_n) begin
      frame_w = FRAME_SIZE_RESET;
      frame_h = FRAME_SIZE_RESET;
      foreach (depth_mem[i]) begin
        depth_mem[i] = '0;
        color_mem[i] = '0;
      end
      expected_results.delete();
    end else begin
      // Compare a result against the oldest outstanding prediction.
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_res);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          bad  = 1'b0;
          bad |= field_differs("depth_passed", want.depth_passed, out_res.depth_passed);
          bad |= field_differs("out_of_range", want.out_of_range, out_res.out_of_range);
          bad |= field_differs("pixel_x", want.pixel_x, out_res.pixel_x);
          bad |= field_differs("pixel_y", want.pixel_y, out_res.pixel_y);
          bad |= field_differs("stored_depth", want.stored_depth, out_res.stored_depth);
          bad |= field_differs("stored_red", want.stored_red, out_res.stored_red);
          bad |= field_differs("stored_green", want.stored_green, out_res.stored_green);
          bad |= field_differs("stored_blue", want.stored_blue, out_res.stored_blue);
          if (bad)
            mismatch_count++;
        end
      end
      // Predict each accepted request with the frame size in force now.
      if (start && !busy)
        expected_results.push_back(apply_request(in_req));
      // A frame size write takes effect for the next request.
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH: begin
            frame_w = cfg_data;
          end
          CFG_FRAME_HEIGHT: begin
            frame_h = cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
    waiting = expected_results.size();
  end

endmodule

// ----- dv/depth_tested_pixel_merge_test.sv -----
// ----------------------------------------------------------------------------
// Depth-tested pixel merge testbench
// Drives directed fragments and reads at the coordinate, depth and frame size
// corners, then random phases over a range of frame sizes in which fragments
// mostly land on a few shared pixels so that depth tests both win and lose.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module depth_tested_pixel_merge_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dtpm_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 128;
  localparam int unsigned LATENCY         = 5;
  localparam int unsigned STALL_LIMIT     = 262144;
  localparam int unsigned POOL_SIZE       = 6;

  localparam logic signed [15:0] NDC_MIN = 16'sh8000;
  localparam logic signed [15:0] NDC_MAX = 16'sh7FFF;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_req_t               in_req;
  logic                  out_valid;
  out_res_t              out_res;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           pending;
  int unsigned           failures;

  // Positions that fragments of one phase keep coming back to.
  logic signed [15:0] pool_x [POOL_SIZE];
  logic signed [15:0] pool_y [POOL_SIZE];

  depth_tested_pixel_merge DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  depth_tested_pixel_merge_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .failures  (failures)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop the run when neither a request nor a result moves for too long.
  // The limit covers the store sweep that follows reset.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid)
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // Build a fragment request; the read fields carry noise.
  function automatic in_req_t fragment(input logic signed [15:0] x, input logic signed [15:0] y,
                                       input logic signed [15:0] z, input logic [15:0] red,
                                       input logic [15:0] green, input logic [15:0] blue);
    in_req_t r;
    r             = '0;
    r.kind        = KIND_FRAGMENT;
    r.pos_x       = x;
    r.pos_y       = y;
    r.pos_z       = z;
    r.color_red   = red;
    r.color_green = green;
    r.color_blue  = blue;
    r.read_x      = 8'($urandom);
    r.read_y      = 8'($urandom);
    return r;
  endfunction

  // Build a read request; the fragment fields carry noise.
  function automatic in_req_t read_back(input logic [7:0] x, input logic [7:0] y);
    in_req_t r;
    r             = '0;
    r.kind        = KIND_READ;
    r.pos_x       = 16'($urandom);
    r.pos_y       = 16'($urandom);
    r.pos_z       = 16'($urandom);
    r.color_red   = 16'($urandom);
    r.color_green = 16'($urandom);
    r.color_blue  = 16'($urandom);
    r.read_x      = x;
    r.read_y      = y;
    return r;
  endfunction

  // Offer one request, after an optional idle burst, and wait for acceptance.
  task automatic push_request(input in_req_t r, input bit may_idle);
    int unsigned gap;
    gap = 0;
    if (may_idle && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 16);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req <= r;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Stop offering requests and wait until every result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Write both frame size registers; no request is in flight here.
  task automatic set_frame(input logic [8:0] w, input logic [8:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random phase at a given frame size. Most fragments reuse a small
  // set of positions so pixels get hit again and again.
  task automatic run_phase(input logic [8:0] w, input logic [8:0] h, input bit may_idle);
    int unsigned        pick;
    int unsigned        span_x;
    int unsigned        span_y;
    logic signed [15:0] z;
    in_req_t            r;
    set_frame(w, h);
    foreach (pool_x[i]) begin
      pool_x[i] = 16'($urandom);
      pool_y[i] = 16'($urandom);
    end
    // Reads reach one past the frame edge where the field allows it.
    span_x = (w > 255) ? 255 : w;
    span_y = (h > 255) ? 255 : h;
    repeat (ITEMS_PER_PHASE) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0)
        z = $urandom_range(0, 1) ? NDC_MAX : NDC_MIN;
      else
        z = 16'($urandom);
      if (pick < 55)
        r = fragment(pool_x[$urandom_range(0, POOL_SIZE-1)],
                     pool_y[$urandom_range(0, POOL_SIZE-1)], z,
                     16'($urandom), 16'($urandom), 16'($urandom));
      else if (pick < 75)
        r = fragment(16'($urandom), 16'($urandom), z,
                     16'($urandom), 16'($urandom), 16'($urandom));
      else if (pick < 95)
        r = read_back(8'($urandom_range(0, span_x)), 8'($urandom_range(0, span_y)));
      else
        r = read_back(8'($urandom), 8'($urandom));
      push_request(r, may_idle);
    end
    drain();
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Full frame: corner positions, depth extremes, ties and rounding ties.
    set_frame(9'd256, 9'd256);
    push_request(fragment(NDC_MIN, NDC_MIN, 16'sd0, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
    push_request(fragment(NDC_MIN, NDC_MIN, NDC_MAX, 16'h0001, 16'h0002, 16'h0003), 1'b1);
    push_request(fragment(NDC_MIN, NDC_MIN, 16'sd0, 16'h0004, 16'h0005, 16'h0006), 1'b1);
    push_request(fragment(NDC_MIN, NDC_MIN, NDC_MIN, 16'h0000, 16'h0000, 16'h0000), 1'b1);
    push_request(fragment(NDC_MAX, NDC_MAX, 16'sd0, 16'hAAAA, 16'h5555, 16'h1234), 1'b1);
    push_request(fragment(16'sd0, 16'sd0, NDC_MAX, 16'h8000, 16'h7FFF, 16'hFFFF), 1'b1);
    push_request(fragment(16'sd64, 16'sd192, -16'sd1, 16'h1111, 16'h2222, 16'h3333), 1'b1);
    push_request(fragment(-16'sd64, -16'sd192, 16'sd5, 16'h4444, 16'h5555, 16'h6666), 1'b1);
    push_request(read_back(8'd0, 8'd0), 1'b1);
    push_request(read_back(8'd128, 8'd128), 1'b1);
    push_request(read_back(8'd255, 8'd255), 1'b1);
    push_request(read_back(8'd128, 8'd127), 1'b1);
    drain();

    // Tiny frame: the stores keep their contents across the size change.
    set_frame(9'd5, 9'd3);
    push_request(fragment(NDC_MAX, NDC_MAX, 16'sd0, 16'h0F0F, 16'hF0F0, 16'h00FF), 1'b1);
    push_request(fragment(NDC_MIN, 16'sd0, 16'sd100, 16'hBEEF, 16'hCAFE, 16'h0BAD), 1'b1);
    push_request(read_back(8'd7, 8'd1), 1'b1);
    push_request(read_back(8'd4, 8'd2), 1'b1);
    push_request(read_back(8'd0, 8'd0), 1'b1);
    drain();

    // Zero size: everything falls outside the frame.
    set_frame(9'd0, 9'd0);
    push_request(fragment(16'sd0, 16'sd0, NDC_MIN, 16'h1357, 16'h2468, 16'h9ABC), 1'b1);
    push_request(read_back(8'd0, 8'd0), 1'b1);
    drain();

    // Sizes beyond the store: only the store bounds limit the pixel.
    set_frame(9'd511, 9'd300);
    push_request(fragment(NDC_MAX, 16'sd0, 16'sd0, 16'h0001, 16'h0001, 16'h0001), 1'b1);
    push_request(fragment(16'sd0, 16'sd0, NDC_MIN, 16'hFFFE, 16'hFFFD, 16'hFFFC), 1'b1);
    push_request(read_back(8'd255, 8'd150), 1'b1);
    drain();

    // Random phases over a spread of frame sizes; the last one never idles.
    run_phase(9'd256, 9'd256, 1'b1);
    run_phase(9'd1, 9'd1, 1'b1);
    run_phase(9'd4, 9'd3, 1'b1);
    run_phase(9'd511, 9'd511, 1'b1);
    run_phase(9'd256, 9'd1, 1'b1);
    run_phase(9'd2, 9'd256, 1'b1);
    run_phase(9'd300, 9'd17, 1'b1);
    run_phase(9'd0, 9'd5, 1'b1);
    run_phase(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)), 1'b0);

    if (failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
